// ----- hdl/scm_pkg.sv -----
package scm_pkg;

    localparam int unsigned DefStackDepth = 256;
    localparam int unsigned WordW  = 64;
    localparam int unsigned DepthW = 9;

    typedef enum logic [3:0] {
        OP_PUSH = 4'd0,
        OP_SWAP = 4'd1,
        OP_ADD  = 4'd2,
        OP_SUB  = 4'd3,
        OP_MUL  = 4'd4,
        OP_DIV  = 4'd5,
        OP_MAX  = 4'd6,
        OP_MIN  = 4'd7,
        OP_NEG  = 4'd8,
        OP_DUP  = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DIVZERO   = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_TOP,
        ST_RD_SEC,
        ST_LATCH,
        ST_MUL,
        ST_DIV,
        ST_WR_SEC,
        ST_WR_TOP,
        ST_RD_BOT,
        ST_BOT,
        ST_OUT
    } t_state;

    // multiplier handshake
    typedef struct packed {
        logic start;
        logic busy;
    } t_unit_ctl;

endpackage

// ----- hdl/scm_ram.sv -----
module scm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/scm_div.sv -----
module scm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    logic [63:0] r_q;
    logic [63:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_neg;
    logic        r_busy;
    logic [64:0] w_trial;
    logic [64:0] w_diff;

    // one restoring step per cycle on magnitudes
    assign w_trial = {r_rem, r_q[63]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
            r_q    <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_den  <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_rem  <= '0;
            r_neg  <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_rem <= w_diff[63:0];
            end else begin
                r_rem <= w_trial[63:0];
            end
            r_q   <= {r_q[62:0], ~w_diff[64]};
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? (64'd0 - r_q) : r_q;
endmodule

// ----- hdl/scm_mul.sv -----
module scm_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scm_pkg::t_unit_ctl   i_ctl,
    input  logic [63:0]          i_a,
    input  logic [63:0]          i_b,
    output logic                 o_busy,
    output logic [63:0]          o_prod
);
    import scm_pkg::*;

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic [31:0] w_pa;
    logic [31:0] w_pb;
    logic [63:0] w_pp;
    logic [63:0] w_term;

    // low 64 bits from three 32x32 partial products, one a cycle
    always_comb begin
        w_pa = r_a[31:0];
        w_pb = r_b[31:0];
        unique case (r_step)
            2'd0: begin w_pa = r_a[31:0];  w_pb = r_b[31:0];  end
            2'd1: begin w_pa = r_a[63:32]; w_pb = r_b[31:0];  end
            2'd2: begin w_pa = r_a[31:0];  w_pb = r_b[63:32]; end
            default: begin w_pa = '0; w_pb = '0; end
        endcase
        w_pp   = {32'd0, w_pa} * {32'd0, w_pb};
        w_term = (r_step == 2'd0) ? w_pp : {w_pp[31:0], 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_acc  <= r_acc + w_term;
            r_step <= r_step + 2'd1;
            if (r_step == 2'd2) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;
endmodule

// ----- hdl/stack_calculator_machine.sv -----
// channel | signals                                         | direction
// input   | i_valid, o_stall, i_action, i_value             | in
// result  | o_valid, i_stall, o_top_value, o_bottom_value,  | out
//         | o_depth, o_error                                |
// one item at a time; each item steps through the read, latch, write, bottom-read
// and output states, swap adds a second write and a failed item skips the
// writes; the result register loads in the output state.
// between latch and write, mul waits on the partial-product multiplier and div
// on the bit-serial divider.
// the stack store is a single-port-write RAM with a registered read.
// reset clears depth and control only; the store needs no clearing pass.
// a held result keeps the machine in its output state until the result is
// taken, so the next item waits behind it.
module stack_calculator_machine #(
    parameter int unsigned STACK_DEPTH = scm_pkg::DefStackDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [3:0]   i_action,
    input  logic [63:0]  i_value,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [63:0]  o_top_value,
    output logic [63:0]  o_bottom_value,
    output logic [8:0]   o_depth,
    output logic [1:0]   o_error
);
    import scm_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    t_state      r_state, n_state;
    logic [CW-1:0] r_depth, n_depth;
    logic [3:0]  r_op;
    logic [63:0] r_val;
    logic [63:0] r_top, r_sec, r_res;
    logic [1:0]  r_err, n_err;
    logic [63:0] r_bot;
    logic        r_ovalid;
    logic [63:0] r_otop, r_obot;
    logic [DepthW-1:0] r_odepth;
    logic [1:0]  r_oerr;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [63:0]   w_wdata, w_rdata;
    logic [63:0]   w_quot, w_prod;
    logic          w_div_busy, w_mul_busy, w_div_start;
    t_unit_ctl     w_mul_ctl;
    logic          w_out_free;
    logic [CW-1:0] w_top_idx;

    assign w_top_idx  = r_depth - CW'(1);
    assign w_out_free = !r_ovalid || !i_stall;

    scm_ram #(.WIDTH(WordW), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    scm_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_mul_ctl),
        .i_a    (r_top),
        .i_b    (r_sec),
        .o_busy (w_mul_busy),
        .o_prod (w_prod)
    );

    scm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_top),
        .i_den  (r_sec),
        .o_busy (w_div_busy),
        .o_quot (w_quot)
    );

    // sequencer: next state, store accesses and error checks
    always_comb begin
        n_state        = r_state;
        n_depth        = r_depth;
        n_err          = r_err;
        w_we           = 1'b0;
        w_waddr        = w_top_idx[AW-1:0];
        w_wdata        = r_res;
        w_raddr        = w_top_idx[AW-1:0];
        w_div_start    = 1'b0;
        w_mul_ctl.start = 1'b0;
        w_mul_ctl.busy  = w_mul_busy;
        o_stall        = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = ST_RD_TOP;
                    n_err   = ERR_OK;
                end
            end
            ST_RD_TOP: begin
                n_state = ST_RD_SEC;
                w_raddr = w_top_idx[AW-1:0];
            end
            ST_RD_SEC: begin
                n_state = ST_LATCH;
                w_raddr = AW'(r_depth - CW'(2));
            end
            ST_LATCH: begin
                n_state = ST_WR_SEC;
                priority if (r_op == OP_PUSH || r_op == OP_DUP) begin
                    if (r_op == OP_DUP && r_depth == '0) begin
                        n_err = ERR_UNDERFLOW;
                        n_state = ST_RD_BOT;
                    end else if (r_depth >= CW'(STACK_DEPTH)) begin
                        n_err = ERR_OVERFLOW;
                        n_state = ST_RD_BOT;
                    end
                end else if (r_op == OP_NEG) begin
                    if (r_depth == '0) begin
                        n_err = ERR_UNDERFLOW;
                        n_state = ST_RD_BOT;
                    end
                end else if (r_op >= OP_SWAP && r_op <= OP_MIN) begin
                    if (r_depth < CW'(2)) begin
                        n_err = ERR_UNDERFLOW;
                        n_state = ST_RD_BOT;
                    end else if (r_op == OP_DIV && w_rdata == '0) begin
                        n_err = ERR_DIVZERO;
                        n_state = ST_RD_BOT;
                    end else if (r_op == OP_DIV) begin
                        n_state = ST_DIV;
                    end else if (r_op == OP_MUL) begin
                        n_state = ST_MUL;
                    end
                end else begin
                    n_state = ST_RD_BOT;
                end
            end
            ST_MUL: begin
                if (!w_mul_busy && r_val[0]) begin
                    n_state = ST_WR_SEC;
                end
                w_mul_ctl.start = !r_val[0];
            end
            ST_DIV: begin
                w_div_start = !r_val[0];
                if (r_val[0] && !w_div_busy) begin
                    n_state = ST_WR_SEC;
                end
            end
            ST_WR_SEC: begin
                n_state = ST_RD_BOT;
                w_we    = 1'b1;
                unique case (r_op)
                    OP_PUSH, OP_DUP: begin
                        w_waddr = r_depth[AW-1:0];
                        n_depth = r_depth + CW'(1);
                    end
                    OP_NEG: begin
                        w_waddr = w_top_idx[AW-1:0];
                    end
                    OP_SWAP: begin
                        w_waddr = AW'(r_depth - CW'(2));
                        n_state = ST_WR_TOP;
                    end
                    default: begin
                        w_waddr = AW'(r_depth - CW'(2));
                        n_depth = r_depth - CW'(1);
                    end
                endcase
            end
            ST_WR_TOP: begin
                n_state = ST_RD_BOT;
                w_we    = 1'b1;
                w_waddr = w_top_idx[AW-1:0];
                w_wdata = r_sec;
            end
            ST_RD_BOT: begin
                n_state = ST_BOT;
                w_raddr = '0;
            end
            ST_BOT: begin
                n_state = ST_OUT;
                w_raddr = w_top_idx[AW-1:0];
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers: state, depth, error and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_depth  <= '0;
            r_err    <= ERR_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_err   <= n_err;
            if (r_state == ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath: operands, result selection and output register
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_op  <= i_action;
                r_val <= i_value;
            end
            ST_RD_SEC: r_top <= w_rdata;
            ST_LATCH: begin
                r_sec <= w_rdata;
                unique case (r_op)
                    OP_PUSH: r_res <= r_val;
                    OP_DUP:  r_res <= r_top;
                    OP_NEG:  r_res <= 64'd0 - r_top;
                    OP_SWAP: r_res <= r_top;
                    OP_ADD:  r_res <= w_rdata + r_top;
                    OP_SUB:  r_res <= r_top - w_rdata;
                    OP_MAX:  r_res <= ($signed(w_rdata) < $signed(r_top)) ? r_top : w_rdata;
                    OP_MIN:  r_res <= ($signed(r_top) < $signed(w_rdata)) ? r_top : w_rdata;
                    default: r_res <= '0;
                endcase
                r_val[0] <= 1'b0;
            end
            ST_MUL: begin
                r_val[0] <= 1'b1;
                if (r_val[0] && !w_mul_busy) begin
                    r_res <= w_prod;
                end
            end
            ST_DIV: begin
                r_val[0] <= 1'b1;
                if (r_val[0] && !w_div_busy) begin
                    r_res <= w_quot;
                end
            end
            ST_BOT: r_bot <= w_rdata;
            ST_OUT: begin
                if (w_out_free) begin
                    r_otop   <= (r_depth == '0) ? 64'd0 : w_rdata;
                    r_obot   <= (r_depth == '0) ? 64'd0 : r_bot;
                    r_odepth <= DepthW'(r_depth);
                    r_oerr   <= r_err;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_ovalid;
    assign o_top_value    = r_otop;
    assign o_bottom_value = r_obot;
    assign o_depth        = r_odepth;
    assign o_error        = r_oerr;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CW'(STACK_DEPTH)) else $error("depth beyond stack size");
    a_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> r_state == ST_IDLE) else $error("item taken while busy");
    a_err_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_err != ERR_OK) |-> $stable(r_depth))
        else $error("failed item changed depth");
`endif
endmodule
